// ===== hw/rtl/efc_pkg.sv =====
`timescale 1ns / 1ps

package efc_pkg;

    localparam int NumFloors = 4;

    // ascii '0' and the last floor digit
    localparam logic [7:0] CharFloor0 = 8'h30;
    localparam logic [1:0] TopFloor   = 2'd3;

    localparam logic [15:0] DoorWaitReset   = 16'd200;
    localparam logic [15:0] ReversalReset   = 16'd50;
    localparam logic [9:0]  TelemetryReset  = 10'd30;
    localparam logic [9:0]  TopPositionReset = 10'd180;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DOOR_WAIT = 2'd0,
        CFG_REVERSAL  = 2'd1,
        CFG_TELEMETRY = 2'd2,
        CFG_TOP_POS   = 2'd3
    } cfg_index_t;

    // control state machine, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_UP   = 5'b00010,
        MODE_DOWN = 5'b00100,
        MODE_DOOR = 5'b01000,
        MODE_REV  = 5'b10000
    } mode_t;

    // reported control state codes
    localparam logic [2:0] CtrlIdle = 3'd0;
    localparam logic [2:0] CtrlUp   = 3'd1;
    localparam logic [2:0] CtrlDown = 3'd2;
    localparam logic [2:0] CtrlDoor = 3'd3;
    localparam logic [2:0] CtrlRev  = 3'd4;

    typedef enum logic [1:0] {
        MOT_STOP = 2'd0,
        MOT_ASC  = 2'd1,
        MOT_DESC = 2'd2
    } motion_t;

    typedef struct packed {
        logic [15:0] door_wait_ticks;
        logic [15:0] reversal_ticks;
        logic [9:0]  telemetry_ticks;
        logic [9:0]  top_position_mm;
    } efc_cfg_t;

    typedef struct packed {
        logic       req_valid;
        logic [7:0] origin_char;
        logic [7:0] dest_char;
        logic       sensor_floor0_n;
        logic       sensor_floor1_n;
        logic       sensor_floor2;
        logic       sensor_floor3;
    } efc_in_t;

    typedef struct packed {
        logic       motor_run;
        logic       motor_dir;
        logic [2:0] ctrl_state;
        logic [1:0] motion_state;
        logic [1:0] floor_now;
        logic [1:0] floor_goal;
        logic [3:0] pending_mask;
        logic       position_load;
        logic [9:0] position_value;
        logic       telemetry_due;
    } efc_out_t;

    typedef struct packed {
        logic       found;
        logic [1:0] floor;
    } efc_stop_t;

    function automatic logic [2:0] mode_code(input mode_t mode);
        logic [2:0] code;
        code = CtrlIdle;
        unique case (mode)
            MODE_IDLE: code = CtrlIdle;
            MODE_UP:   code = CtrlUp;
            MODE_DOWN: code = CtrlDown;
            MODE_DOOR: code = CtrlDoor;
            MODE_REV:  code = CtrlRev;
            default:   code = CtrlIdle;
        endcase
        return code;
    endfunction

    // directional pick, falls back to lowest pending floor
    function automatic efc_stop_t next_stop(input mode_t mode, input logic [1:0] floor,
                                            input logic [3:0] reqs);
        efc_stop_t dir_pick;
        efc_stop_t low_pick;
        dir_pick = '0;
        low_pick = '0;
        for (int i = NumFloors - 1; i >= 0; i--) begin
            if (reqs[i]) begin
                low_pick.found = 1'b1;
                low_pick.floor = 2'(i);
                if (mode == MODE_UP && 2'(i) > floor) begin
                    dir_pick.found = 1'b1;
                    dir_pick.floor = 2'(i);
                end
            end
        end
        if (mode == MODE_DOWN) begin
            for (int i = 0; i < NumFloors; i++) begin
                if (reqs[i] && 2'(i) < floor) begin
                    dir_pick.found = 1'b1;
                    dir_pick.floor = 2'(i);
                end
            end
        end
        return dir_pick.found ? dir_pick : low_pick;
    endfunction

endpackage

// ===== hw/rtl/elevator_floor_controller_top.sv =====
// a held input word steps the core and its result word is registered for m_valid
// throughput: one word per cycle; s_ready drops only while a result word is stalled
// at m_ready low with another word already held in the input register
// reset: aresetn synchronous active low; clears both stage valids, the control state,
// counters and pending calls, and loads the configuration registers with their defaults
`timescale 1ns / 1ps

module elevator_floor_controller_top
    import efc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // tick words in
    input  logic        s_valid,
    output logic        s_ready,
    input  efc_in_t     s_data,

    // result words out
    output logic        m_valid,
    input  logic        m_ready,
    output efc_out_t    m_data,

    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    efc_cfg_t cfg;

    // input register
    logic     in_valid_reg;
    efc_in_t  in_data_reg;

    // result register
    logic     out_valid_reg;
    efc_out_t out_data_reg;

    efc_out_t step_result;
    logic     advance;

    // the held word steps the controller when the result register can take it
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    efc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // control state machine, counters and target pick, one tick per advance
    efc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_data_reg),
        .advance (advance),
        .result  (step_result)
    );

    // input register: loads whenever the slot is free or being emptied
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // result register: holds the word until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== hw/rtl/efc_cfg.sv =====
`timescale 1ns / 1ps

module efc_cfg
    import efc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output efc_cfg_t    cfg
);

    efc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.door_wait_ticks <= DoorWaitReset;
            cfg_reg.reversal_ticks  <= ReversalReset;
            cfg_reg.telemetry_ticks <= TelemetryReset;
            cfg_reg.top_position_mm <= TopPositionReset;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DOOR_WAIT: cfg_reg.door_wait_ticks <= cfg_data;
                CFG_REVERSAL:  cfg_reg.reversal_ticks  <= cfg_data;
                CFG_TELEMETRY: cfg_reg.telemetry_ticks <= cfg_data[9:0];
                CFG_TOP_POS:   cfg_reg.top_position_mm <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/efc_core.sv =====
`timescale 1ns / 1ps

module efc_core
    import efc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  efc_cfg_t cfg,
    input  efc_in_t  item,
    input  logic     advance,
    output efc_out_t result
);

    mode_t       mode_reg,  mode_next;
    motion_t     motion_reg, motion_next;
    logic        dir_reg,   dir_next;
    logic [1:0]  floor_reg, floor_next;
    logic [1:0]  goal_reg,  goal_next;
    logic [3:0]  req_reg,   req_next;
    logic [15:0] wait_reg,  wait_next;
    logic [9:0]  tele_reg,  tele_next;

    logic        pos_load;
    logic [9:0]  pos_val;
    logic        tele_due;
    efc_stop_t   stop;
    logic [15:0] wait_inc;
    logic [9:0]  tele_inc;

    always_comb begin
        req_next    = req_reg;
        floor_next  = floor_reg;
        motion_next = motion_reg;
        mode_next   = mode_reg;
        dir_next    = dir_reg;
        goal_next   = goal_reg;
        wait_next   = wait_reg;
        pos_load    = 1'b0;
        pos_val     = '0;
        stop        = '0;
        wait_inc    = wait_reg + 16'd1;

        // call digits outside '0'..'3' are dropped
        if (item.req_valid) begin
            if (item.origin_char[7:2] == CharFloor0[7:2]) begin
                req_next[item.origin_char[1:0]] = 1'b1;
            end
            if (item.dest_char[7:2] == CharFloor0[7:2]) begin
                req_next[item.dest_char[1:0]] = 1'b1;
            end
        end

        if (!item.sensor_floor0_n) floor_next = 2'd0;
        if (!item.sensor_floor1_n) floor_next = 2'd1;
        if (item.sensor_floor2)    floor_next = 2'd2;
        if (item.sensor_floor3)    floor_next = TopFloor;

        // limit switches
        if (!item.sensor_floor0_n && motion_next == MOT_DESC) begin
            motion_next = MOT_STOP;
            mode_next   = MODE_IDLE;
            pos_load    = 1'b1;
        end
        if (item.sensor_floor3 && motion_next == MOT_ASC) begin
            motion_next = MOT_STOP;
            mode_next   = MODE_IDLE;
            pos_load    = 1'b1;
            pos_val     = cfg.top_position_mm;
        end

        stop = next_stop(mode_next, floor_next, req_next);

        unique case (mode_next)
            MODE_IDLE: begin
                if (stop.found) begin
                    goal_next = stop.floor;
                    if (stop.floor > floor_next) begin
                        dir_next    = 1'b1;
                        motion_next = MOT_ASC;
                        mode_next   = MODE_UP;
                    end else if (stop.floor < floor_next) begin
                        dir_next    = 1'b0;
                        motion_next = MOT_DESC;
                        mode_next   = MODE_DOWN;
                    end else begin
                        motion_next           = MOT_STOP;
                        req_next[floor_next]  = 1'b0;
                        mode_next             = MODE_DOOR;
                        wait_next             = '0;
                    end
                end else if (floor_next != 2'd0) begin
                    req_next[0] = 1'b1;
                end
            end
            MODE_UP, MODE_DOWN: begin
                if (stop.found) begin
                    goal_next = stop.floor;
                end
                if (floor_next == goal_next) begin
                    motion_next          = MOT_STOP;
                    req_next[floor_next] = 1'b0;
                    mode_next            = MODE_DOOR;
                    wait_next            = '0;
                end
            end
            MODE_DOOR: begin
                wait_next = wait_inc;
                if (wait_inc >= cfg.door_wait_ticks) begin
                    if (stop.found) begin
                        mode_next = MODE_REV;
                        wait_next = '0;
                    end else begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_REV: begin
                wait_next = wait_inc;
                if (wait_inc >= cfg.reversal_ticks) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    always_comb begin
        tele_inc  = tele_reg + 10'd1;
        tele_due  = (tele_inc >= cfg.telemetry_ticks);
        tele_next = tele_due ? '0 : tele_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            motion_reg <= MOT_STOP;
            dir_reg    <= 1'b0;
            floor_reg  <= '0;
            goal_reg   <= '0;
            req_reg    <= '0;
            wait_reg   <= '0;
            tele_reg   <= '0;
        end else if (advance) begin
            mode_reg   <= mode_next;
            motion_reg <= motion_next;
            dir_reg    <= dir_next;
            floor_reg  <= floor_next;
            goal_reg   <= goal_next;
            req_reg    <= req_next;
            wait_reg   <= wait_next;
            tele_reg   <= tele_next;
        end
    end

    always_comb begin
        result.motor_run      = (motion_next != MOT_STOP);
        result.motor_dir      = dir_next;
        result.ctrl_state     = mode_code(mode_next);
        result.motion_state   = motion_next;
        result.floor_now      = floor_next;
        result.floor_goal     = goal_next;
        result.pending_mask   = req_next;
        result.position_load  = pos_load;
        result.position_value = pos_val;
        result.telemetry_due  = tele_due;
    end

endmodule

// ===== hw/rtl/efc_checker.sv =====
`timescale 1ns / 1ps

module efc_checker
    import efc_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input efc_out_t m_data
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // input side only stalls behind a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.position_load |-> m_data.position_value == '0)
        else $error("position value without a load");

    // ascending motion only in the up state, with the up direction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.motion_state == MOT_ASC
            |-> m_data.ctrl_state == CtrlUp && m_data.motor_dir && m_data.motor_run)
        else $error("ascending outside the up state");

endmodule

bind elevator_floor_controller_top efc_checker u_efc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
